### hdl/plvi_pkg.sv
// shared types and constants for the point light vertex intensity block
`timescale 1ns / 1ps
`default_nettype none

package plvi_pkg;

    // field widths
    localparam int NRM_W    = 16;   // Q2.14 normal component
    localparam int POS_W    = 20;   // Q16.4 position coordinate
    localparam int VEC_W    = 21;   // light vector and rotated normal components
    localparam int SQ_W     = 42;   // squared length
    localparam int LEN_W    = 21;   // floor square root of a squared length
    localparam int DOT_W    = 44;   // signed dot product
    localparam int FRAC_SH  = 12;   // Q.28 to Q.16
    localparam int COS_W    = 16;
    localparam int QUO_W    = 18;   // quotient bits, ratio stays below four
    localparam int UNIT_SH  = 15;   // scale by 32768
    localparam int ANUM_W   = DOT_W + UNIT_SH - 0;  // |dot| << 15
    localparam int ADEN_W   = 2 * LEN_W;
    localparam int SNUM_W   = VEC_W + UNIT_SH;
    localparam int ROW_W    = 48;
    localparam int LIGHT_W  = 60;
    localparam int GAIN_W   = 24;
    localparam int CFG_W    = 60;
    localparam int CFG_IDX_W = 3;
    localparam int SUM_W    = 18;   // clamped cosine plus offset
    localparam int UV_W     = 16;

    // pipeline depths
    localparam int FRONT_LAT = 4;
    localparam int SQRT_LAT  = LEN_W;
    localparam int DIV_LAT   = QUO_W;
    localparam int TOTAL_LAT = FRONT_LAT + SQRT_LAT + 1 + DIV_LAT + 2;

    localparam logic [QUO_W-1:0] UNIT_Q = QUO_W'(32768);

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW0   = 3'd0,
        CFG_ROW1   = 3'd1,
        CFG_ROW2   = 3'd2,
        CFG_LIGHT  = 3'd3,
        CFG_OFFSET = 3'd4,
        CFG_GAIN   = 3'd5,
        CFG_MINCOS = 3'd6,
        CFG_ENV    = 3'd7
    } t_cfg_idx;

    // geometry settings used by the front end
    typedef struct packed {
        logic [ROW_W-1:0]   row0;
        logic [ROW_W-1:0]   row1;
        logic [ROW_W-1:0]   row2;
        logic [LIGHT_W-1:0] light;
    } t_geom_cfg;

    // flags that travel beside the dividers
    typedef struct packed {
        logic neg_a;
        logic neg_u;
        logic neg_v;
        logic degen;
        logic rzero;
    } t_side;

endpackage

`default_nettype wire

### hdl/point_light_vertex_intensity_top.sv
// top level of the point light vertex intensity pipeline
// Usage: one vertex per request on the s_axis channel (normal and projected
// position packed in s_axis_tdata); one result per vertex on m_axis with the
// light value and sphere-map u and v in m_axis_tdata and the zero-length flag
// in m_axis_tuser. Settings are written through the cfg channel, which is
// always ready; write them only while no vertex is in flight.
// Path from input request to output request: the front end (rotation,
// squares, sums), 21 square root digit stages, one length multiply, 18
// divider quotient stages, then the clamp register and the output register.
// Throughput: one vertex per cycle unless stalled; each stage holds one vertex.
// A stalled receiver holds the whole pipeline in place: s_axis_tready drops
// while a result waits on m_axis, and resumes the cycle it is taken.
// Reset: the valid bits clear at once, the settings return to the identity
// matrix, light at origin, offset 32768, gain 65536, min cosine zero and
// env mode off. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module point_light_vertex_intensity_top
    import plvi_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // config write channel
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    // vertex input
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // normal_x, normal_y, normal_z (16 each), vertex_x, vertex_y, vertex_z (20 each), pad
    input  wire logic [111:0]         s_axis_tdata,
    // result output
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // light_value (24), env_u (16), env_v (16)
    output logic [55:0]               m_axis_tdata,
    // degenerate
    output logic                      m_axis_tuser
);

    // settings
    logic [ROW_W-1:0]        r_row0;
    logic [ROW_W-1:0]        r_row1;
    logic [ROW_W-1:0]        r_row2;
    logic [LIGHT_W-1:0]      r_light;
    logic [COS_W-1:0]        r_offset;
    logic [GAIN_W-1:0]       r_gain;
    logic signed [COS_W-1:0] r_minc;
    logic                    r_env;
    t_geom_cfg               geom;

    logic                    en;
    logic                    r_vld [TOTAL_LAT];

    logic [SQ_W-1:0]         p2;
    logic [SQ_W-1:0]         r2;
    logic signed [DOT_W-1:0] dot;
    logic signed [VEC_W-1:0] rx;
    logic signed [VEC_W-1:0] ry;
    logic [LEN_W-1:0]        len_p;
    logic [LEN_W-1:0]        len_r;

    logic signed [DOT_W-1:0] r_dot_d [SQRT_LAT];
    logic signed [VEC_W-1:0] r_rx_d  [SQRT_LAT];
    logic signed [VEC_W-1:0] r_ry_d  [SQRT_LAT];

    logic [DOT_W-1:0]        dot_mag;
    logic [VEC_W-1:0]        rx_mag;
    logic [VEC_W-1:0]        ry_mag;
    logic signed [DOT_W-1:0] dot_s;
    logic signed [VEC_W-1:0] rx_s;
    logic signed [VEC_W-1:0] ry_s;

    logic [ANUM_W-1:0]       r_num_a;
    logic [ADEN_W-1:0]       r_den_a;
    logic [SNUM_W-1:0]       r_num_u;
    logic [SNUM_W-1:0]       r_num_v;
    logic [LEN_W-1:0]        r_den_s;
    t_side                   r_side_m;
    t_side                   r_side_d [DIV_LAT];
    t_side                   side_o;

    logic [QUO_W-1:0]        q_a;
    logic [QUO_W-1:0]        q_u;
    logic [QUO_W-1:0]        q_v;
    logic [QUO_W-1:0]        m_a;
    logic [QUO_W-1:0]        m_u;
    logic [QUO_W-1:0]        m_v;
    logic signed [SUM_W-1:0] a_val;
    logic signed [SUM_W-1:0] a_sel;
    logic signed [SUM_W-1:0] s_val;
    logic [UV_W:0]           u_raw;
    logic [UV_W:0]           v_raw;
    logic [UV_W-1:0]         u_val;
    logic [UV_W-1:0]         v_val;

    logic signed [SUM_W-1:0] r_s;
    logic [UV_W-1:0]         r_u;
    logic [UV_W-1:0]         r_v;
    logic                    r_degen_f;

    logic [SUM_W+GAIN_W-1:0] prod;
    logic [GAIN_W:0]         light_raw;
    logic [GAIN_W-1:0]       light_val;

    logic [GAIN_W-1:0]       r_light_o;
    logic [UV_W-1:0]         r_u_o;
    logic [UV_W-1:0]         r_v_o;
    logic                    r_degen_o;

    // config register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row0   <= ROW_W'(16384);
            r_row1   <= ROW_W'(64'd1073741824);
            r_row2   <= ROW_W'(64'd70368744177664);
            r_light  <= '0;
            r_offset <= COS_W'(32768);
            r_gain   <= GAIN_W'(65536);
            r_minc   <= '0;
            r_env    <= 1'b0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ROW0:   r_row0   <= i_cfg_data[ROW_W-1:0];
                CFG_ROW1:   r_row1   <= i_cfg_data[ROW_W-1:0];
                CFG_ROW2:   r_row2   <= i_cfg_data[ROW_W-1:0];
                CFG_LIGHT:  r_light  <= i_cfg_data[LIGHT_W-1:0];
                CFG_OFFSET: r_offset <= i_cfg_data[COS_W-1:0];
                CFG_GAIN:   r_gain   <= i_cfg_data[GAIN_W-1:0];
                CFG_MINCOS: r_minc   <= i_cfg_data[COS_W-1:0];
                CFG_ENV:    r_env    <= i_cfg_data[0];
                default:    r_env    <= r_env;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    always_comb begin
        geom.row0  = r_row0;
        geom.row1  = r_row1;
        geom.row2  = r_row2;
        geom.light = r_light;
    end

    // pipeline advance and valid bits
    assign en            = m_axis_tready | ~r_vld[TOTAL_LAT-1];
    assign s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TOTAL_LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= s_axis_tvalid;
            for (int k = 1; k < TOTAL_LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // front end
    plvi_front u_front (
        .i_clk (i_clk),
        .i_en  (en),
        .i_cfg (geom),
        .i_nx  (s_axis_tdata[15:0]),
        .i_ny  (s_axis_tdata[31:16]),
        .i_nz  (s_axis_tdata[47:32]),
        .i_vx  (s_axis_tdata[67:48]),
        .i_vy  (s_axis_tdata[87:68]),
        .i_vz  (s_axis_tdata[107:88]),
        .o_p2  (p2),
        .o_r2  (r2),
        .o_dot (dot),
        .o_rx  (rx),
        .o_ry  (ry)
    );

    // vector lengths
    plvi_sqrt #(.IW(SQ_W)) u_sqrt_p (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_x    (p2),
        .o_root (len_p)
    );

    plvi_sqrt #(.IW(SQ_W)) u_sqrt_r (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_x    (r2),
        .o_root (len_r)
    );

    // dot product and normal beside the square roots
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dot_d[0] <= dot;
            r_rx_d[0]  <= rx;
            r_ry_d[0]  <= ry;
            for (int k = 1; k < SQRT_LAT; k++) begin
                r_dot_d[k] <= r_dot_d[k-1];
                r_rx_d[k]  <= r_rx_d[k-1];
                r_ry_d[k]  <= r_ry_d[k-1];
            end
        end
    end

    // magnitudes for the dividers
    always_comb begin
        dot_s   = r_dot_d[SQRT_LAT-1];
        rx_s    = r_rx_d[SQRT_LAT-1];
        ry_s    = r_ry_d[SQRT_LAT-1];
        dot_mag = dot_s[DOT_W-1] ? DOT_W'(-dot_s) : DOT_W'(dot_s);
        rx_mag  = rx_s[VEC_W-1] ? VEC_W'(-rx_s) : VEC_W'(rx_s);
        ry_mag  = ry_s[VEC_W-1] ? VEC_W'(-ry_s) : VEC_W'(ry_s);
    end

    // length product and scaled numerators
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_den_a        <= ADEN_W'(len_p) * ADEN_W'(len_r);
            r_num_a        <= ANUM_W'(dot_mag) << UNIT_SH;
            r_num_u        <= SNUM_W'(rx_mag) << UNIT_SH;
            r_num_v        <= SNUM_W'(ry_mag) << UNIT_SH;
            r_den_s        <= len_r;
            r_side_m.neg_a <= ~dot_s[DOT_W-1] & (dot_s != '0);
            r_side_m.neg_u <= rx_s[VEC_W-1];
            r_side_m.neg_v <= ry_s[VEC_W-1];
            r_side_m.degen <= (len_p == '0) | (len_r == '0);
            r_side_m.rzero <= (len_r == '0);
        end
    end

    // cosine and sphere-map quotients
    plvi_div #(.NW(ANUM_W), .DW(ADEN_W), .QW(QUO_W)) u_div_a (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_num_a),
        .i_den (r_den_a),
        .o_quo (q_a)
    );

    plvi_div #(.NW(SNUM_W), .DW(LEN_W), .QW(QUO_W)) u_div_u (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_num_u),
        .i_den (r_den_s),
        .o_quo (q_u)
    );

    plvi_div #(.NW(SNUM_W), .DW(LEN_W), .QW(QUO_W)) u_div_v (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_num_v),
        .i_den (r_den_s),
        .o_quo (q_v)
    );

    // signs and flags beside the dividers
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side_d[0] <= r_side_m;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_side_d[k] <= r_side_d[k-1];
            end
        end
    end

    assign side_o = r_side_d[DIV_LAT-1];

    // clamp, minimum, offset and sphere coordinates
    always_comb begin
        m_a   = (q_a > UNIT_Q) ? UNIT_Q : q_a;
        m_u   = (q_u > UNIT_Q) ? UNIT_Q : q_u;
        m_v   = (q_v > UNIT_Q) ? UNIT_Q : q_v;
        a_val = side_o.neg_a ? -SUM_W'(m_a) : SUM_W'(m_a);
        a_sel = a_val;
        if (side_o.degen || (a_val < SUM_W'(r_minc))) begin
            a_sel = SUM_W'(r_minc);
        end
        s_val = a_sel + SUM_W'(r_offset);
        u_raw = side_o.neg_u ? ((UV_W+1)'(32768) - (UV_W+1)'(m_u))
                             : ((UV_W+1)'(32768) + (UV_W+1)'(m_u));
        v_raw = side_o.neg_v ? ((UV_W+1)'(32768) - (UV_W+1)'(m_v))
                             : ((UV_W+1)'(32768) + (UV_W+1)'(m_v));
        u_val = u_raw[UV_W] ? '1 : u_raw[UV_W-1:0];
        v_val = v_raw[UV_W] ? '1 : v_raw[UV_W-1:0];
        if (side_o.rzero) begin
            u_val = UV_W'(32768);
            v_val = UV_W'(32768);
        end
        if (!r_env) begin
            u_val = '0;
            v_val = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s       <= s_val;
            r_u       <= u_val;
            r_v       <= v_val;
            r_degen_f <= side_o.degen;
        end
    end

    // gain and saturation
    always_comb begin
        prod      = (SUM_W+GAIN_W)'(r_s[SUM_W-2:0]) * (SUM_W+GAIN_W)'(r_gain);
        light_raw = prod[16 +: GAIN_W+1];
        light_val = light_raw[GAIN_W] ? '1 : light_raw[GAIN_W-1:0];
        if (r_s[SUM_W-1] || (r_s == '0)) begin
            light_val = '0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_light_o <= light_val;
            r_u_o     <= r_u;
            r_v_o     <= r_v;
            r_degen_o <= r_degen_f;
        end
    end

    assign m_axis_tvalid = r_vld[TOTAL_LAT-1];
    assign m_axis_tdata  = {r_v_o, r_u_o, r_light_o};
    assign m_axis_tuser  = r_degen_o;

endmodule

`default_nettype wire

### hdl/plvi_front.sv
// front end: normal rotation, light vector, squared lengths and dot product
`timescale 1ns / 1ps
`default_nettype none

module plvi_front
    import plvi_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire t_geom_cfg                i_cfg,
    input  wire logic signed [NRM_W-1:0]  i_nx,
    input  wire logic signed [NRM_W-1:0]  i_ny,
    input  wire logic signed [NRM_W-1:0]  i_nz,
    input  wire logic signed [POS_W-1:0]  i_vx,
    input  wire logic signed [POS_W-1:0]  i_vy,
    input  wire logic signed [POS_W-1:0]  i_vz,
    output logic        [SQ_W-1:0]        o_p2,
    output logic        [SQ_W-1:0]        o_r2,
    output logic signed [DOT_W-1:0]       o_dot,
    output logic signed [VEC_W-1:0]       o_rx,
    output logic signed [VEC_W-1:0]       o_ry
);

    logic        [ROW_W-1:0]     rows [3];
    logic signed [NRM_W-1:0]     nrm  [3];
    logic signed [POS_W-1:0]     vtx  [3];
    logic signed [POS_W-1:0]     lgt  [3];
    logic signed [NRM_W-1:0]     coef [9];
    logic signed [33:0]          rsum [3];
    logic signed [33:0]          rtrn [3];

    logic signed [31:0]          r_prod [9];
    logic signed [VEC_W-1:0]     r_p1   [3];
    logic signed [VEC_W-1:0]     r_p2   [3];
    logic signed [VEC_W-1:0]     r_r2   [3];
    logic signed [SQ_W-1:0]      r_sp   [3];
    logic signed [SQ_W-1:0]      r_sr   [3];
    logic signed [SQ_W-1:0]      r_pr   [3];
    logic signed [VEC_W-1:0]     r_rx3;
    logic signed [VEC_W-1:0]     r_ry3;
    logic        [SQ_W-1:0]      r_p2o;
    logic        [SQ_W-1:0]      r_r2o;
    logic signed [DOT_W-1:0]     r_doto;
    logic signed [VEC_W-1:0]     r_rxo;
    logic signed [VEC_W-1:0]     r_ryo;

    // operand unpacking
    always_comb begin
        rows[0] = i_cfg.row0;
        rows[1] = i_cfg.row1;
        rows[2] = i_cfg.row2;
        nrm[0]  = i_nx;
        nrm[1]  = i_ny;
        nrm[2]  = i_nz;
        vtx[0]  = i_vx;
        vtx[1]  = i_vy;
        vtx[2]  = i_vz;
        for (int j = 0; j < 3; j++) begin
            lgt[j] = i_cfg.light[POS_W*j +: POS_W];
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                coef[3*i+j] = rows[i][NRM_W*j +: NRM_W];
            end
        end
    end

    // stage 1: matrix products and light vector
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 9; k++) begin
                r_prod[k] <= coef[k] * nrm[k % 3];
            end
            for (int j = 0; j < 3; j++) begin
                r_p1[j] <= {vtx[j][POS_W-1], vtx[j]} - {lgt[j][POS_W-1], lgt[j]};
            end
        end
    end

    // row sums truncated toward zero to Q.16
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rsum[i] = 34'(r_prod[3*i]) + 34'(r_prod[3*i+1]) + 34'(r_prod[3*i+2]);
            rtrn[i] = rsum[i][33] ? (rsum[i] + 34'sd4095) : rsum[i];
        end
    end

    // stage 2: rotated normal
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_r2[i] <= VEC_W'(rtrn[i] >>> FRAC_SH);
                r_p2[i] <= r_p1[i];
            end
        end
    end

    // stage 3: squares and element products for the dot product
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 3; j++) begin
                r_sp[j] <= r_p2[j] * r_p2[j];
                r_sr[j] <= r_r2[j] * r_r2[j];
                r_pr[j] <= r_p2[j] * r_r2[j];
            end
            r_rx3 <= r_r2[0];
            r_ry3 <= r_r2[1];
        end
    end

    // stage 4: sums
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p2o  <= SQ_W'(r_sp[0]) + SQ_W'(r_sp[1]) + SQ_W'(r_sp[2]);
            r_r2o  <= SQ_W'(r_sr[0]) + SQ_W'(r_sr[1]) + SQ_W'(r_sr[2]);
            r_doto <= DOT_W'(r_pr[0]) + DOT_W'(r_pr[1]) + DOT_W'(r_pr[2]);
            r_rxo  <= r_rx3;
            r_ryo  <= r_ry3;
        end
    end

    assign o_p2  = r_p2o;
    assign o_r2  = r_r2o;
    assign o_dot = r_doto;
    assign o_rx  = r_rxo;
    assign o_ry  = r_ryo;

endmodule

`default_nettype wire

### hdl/plvi_sqrt.sv
// pipelined floor square root, one result bit per stage
`timescale 1ns / 1ps
`default_nettype none

module plvi_sqrt
    import plvi_pkg::*;
#(
    parameter int IW = SQ_W
) (
    input  wire logic            i_clk,
    input  wire logic            i_en,
    input  wire logic [IW-1:0]   i_x,
    output logic      [IW/2-1:0] o_root
);

    localparam int OW = IW / 2;

    logic [IW-1:0] r_x [OW];
    logic [IW-1:0] r_r [OW];

    genvar k;
    generate
        for (k = 0; k < OW; k++) begin : g_stage
            localparam logic [IW:0] BIT = {{IW{1'b0}}, 1'b1} << (IW - 2 - 2 * k);
            logic [IW-1:0] x_in;
            logic [IW-1:0] r_in;
            logic [IW:0]   trial;

            if (k == 0) begin : g_first
                assign x_in = i_x;
                assign r_in = '0;
            end else begin : g_next
                assign x_in = r_x[k-1];
                assign r_in = r_r[k-1];
            end

            assign trial = {1'b0, r_in} + BIT;

            // one digit: subtract the trial value when it fits
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if ({1'b0, x_in} >= trial) begin
                        r_x[k] <= x_in - trial[IW-1:0];
                        r_r[k] <= (r_in >> 1) + BIT[IW-1:0];
                    end else begin
                        r_x[k] <= x_in;
                        r_r[k] <= r_in >> 1;
                    end
                end
            end
        end
    endgenerate

    assign o_root = r_r[OW-1][OW-1:0];

endmodule

`default_nettype wire

### hdl/plvi_div.sv
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none

module plvi_div
    import plvi_pkg::*;
#(
    parameter int NW = ANUM_W,
    parameter int DW = ADEN_W,
    parameter int QW = QUO_W
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic      [QW-1:0] o_quo
);

    localparam int RW = (NW > DW + QW) ? NW : DW + QW;

    logic [RW-1:0] r_rem [QW];
    logic [DW-1:0] r_den [QW];
    logic [QW-1:0] r_quo [QW];

    genvar k;
    generate
        for (k = 0; k < QW; k++) begin : g_stage
            localparam int SH = QW - 1 - k;
            logic [RW-1:0] rem_in;
            logic [DW-1:0] den_in;
            logic [QW-1:0] quo_in;
            logic [RW-1:0] den_sh;

            if (k == 0) begin : g_first
                assign rem_in = RW'(i_num);
                assign den_in = i_den;
                assign quo_in = '0;
            end else begin : g_next
                assign rem_in = r_rem[k-1];
                assign den_in = r_den[k-1];
                assign quo_in = r_quo[k-1];
            end

            assign den_sh = RW'(den_in) << SH;

            // compare and subtract the shifted divisor
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_den[k] <= den_in;
                    if (rem_in >= den_sh) begin
                        r_rem[k] <= rem_in - den_sh;
                        r_quo[k] <= quo_in | (QW'(1) << SH);
                    end else begin
                        r_rem[k] <= rem_in;
                        r_quo[k] <= quo_in;
                    end
                end
            end
        end
    endgenerate

    assign o_quo = r_quo[QW-1];

endmodule

`default_nettype wire

### test/testbench.sv
// self-checking testbench for the point light vertex intensity pipeline
`timescale 1ns / 1ps

module testbench;
    import plvi_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int N_RANDOM    = 1500;

    typedef struct packed {
        logic signed [15:0] nx, ny, nz;
        logic signed [19:0] px, py, pz;
    } t_vertex;

    typedef struct packed {
        logic [23:0] light;
        logic [15:0] u;
        logic [15:0] v;
        logic        degen;
    } t_shade;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0] i_cfg_data;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [111:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [55:0] m_axis_tdata;
    logic m_axis_tuser;

    point_light_vertex_intensity_top u_top (.*);

    // shadow copy of the settings
    logic [47:0] sh_row [3];
    logic [59:0] sh_light;
    logic [15:0] sh_offset;
    logic [23:0] sh_gain;
    logic [15:0] sh_mincos;
    logic        sh_env;

    t_vertex vertex_queue[$];
    t_shade  shade_queue[$];
    int      errors = 0;
    longint  cycles = 0;
    int      burst_left = 0;
    int      gap_left = 0;

    function automatic longint floor_sqrt(longint x);
        longint r, b;
        r = 0;
        b = 64'sd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unit_clamp(longint q);
        if (q < -32768) return -32768;
        if (q > 32768) return 32768;
        return q;
    endfunction

    function automatic logic [15:0] sphere_of(longint c, longint len);
        longint q, u;
        q = 0;
        if (len > 0) q = unit_clamp((c * 32768) / len);
        u = 32768 + q;
        if (u > 65535) u = 65535;
        return 16'(u);
    endfunction

    // expected shading of one vertex under the current settings
    function automatic t_shade shade_vertex(t_vertex vx);
        longint n[3], r[3], p[3];
        longint lp, lr, a, s, dot, minc, lv;
        t_shade res;
        n[0] = vx.nx; n[1] = vx.ny; n[2] = vx.nz;
        for (int i = 0; i < 3; i++)
            r[i] = (longint'($signed(sh_row[i][15:0])) * n[0]
                  + longint'($signed(sh_row[i][31:16])) * n[1]
                  + longint'($signed(sh_row[i][47:32])) * n[2]) / 4096;
        p[0] = longint'(vx.px) - longint'($signed(sh_light[19:0]));
        p[1] = longint'(vx.py) - longint'($signed(sh_light[39:20]));
        p[2] = longint'(vx.pz) - longint'($signed(sh_light[59:40]));
        lp = floor_sqrt(p[0]*p[0] + p[1]*p[1] + p[2]*p[2]);
        lr = floor_sqrt(r[0]*r[0] + r[1]*r[1] + r[2]*r[2]);
        minc = longint'($signed(sh_mincos));
        res = '0;
        if (lp == 0 || lr == 0) begin
            a = minc;
            res.degen = 1'b1;
        end else begin
            dot = p[0]*r[0] + p[1]*r[1] + p[2]*r[2];
            a = unit_clamp((-dot * 32768) / (lp * lr));
            if (a < minc) a = minc;
        end
        s = a + longint'(sh_offset);
        if (s > 0) begin
            lv = (s * longint'(sh_gain)) >>> 16;
            if (lv > 16777215) lv = 16777215;
            res.light = 24'(lv);
        end
        if (sh_env) begin
            res.u = sphere_of(r[0], lr);
            res.v = sphere_of(r[1], lr);
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    // vertex driver with random bursts and gaps
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) void'(vertex_queue.pop_front());
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end else if (vertex_queue.size() > 0) begin
                t_vertex nv;
                nv = vertex_queue[0];
                s_axis_tdata <= {4'b0, nv.pz, nv.py, nv.px, nv.nz, nv.ny, nv.nx};
                s_axis_tvalid <= 1'b1;
                shade_queue.push_back(shade_vertex(nv));
                if (burst_left > 0) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(0, 30);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result monitor and stalling receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= (cycles[9:8] == 2'b11) ? 1'b1 : ($urandom_range(0, 3) != 0);
            if (m_axis_tvalid && m_axis_tready) begin
                if (shade_queue.size() == 0) begin
                    report_mismatch("unexpected result", m_axis_tdata, 0);
                end else begin
                    t_shade w;
                    w = shade_queue.pop_front();
                    if (m_axis_tdata[23:0] != w.light)
                        report_mismatch("light_value", m_axis_tdata[23:0], w.light);
                    if (m_axis_tdata[39:24] != w.u)
                        report_mismatch("env_u", m_axis_tdata[39:24], w.u);
                    if (m_axis_tdata[55:40] != w.v)
                        report_mismatch("env_v", m_axis_tdata[55:40], w.v);
                    if (m_axis_tuser != w.degen)
                        report_mismatch("degenerate", m_axis_tuser, w.degen);
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("point_light_vertex_intensity_top regression: fail");
            $finish;
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [59:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_ROW0:   sh_row[0] = val[47:0];
            CFG_ROW1:   sh_row[1] = val[47:0];
            CFG_ROW2:   sh_row[2] = val[47:0];
            CFG_LIGHT:  sh_light = val;
            CFG_OFFSET: sh_offset = val[15:0];
            CFG_GAIN:   sh_gain = val[23:0];
            CFG_MINCOS: sh_mincos = val[15:0];
            CFG_ENV:    sh_env = val[0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (vertex_queue.size() != 0 || s_axis_tvalid || shade_queue.size() != 0)
            @(posedge i_clk);
        repeat (TOTAL_LAT + 4) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_nrm();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [19:0] rand_pos();
        case ($urandom_range(0, 5))
            0: return 20'h80000;
            1: return 20'h7ffff;
            2: return 20'(int'($urandom_range(0, 64)) - 32);
            default: return 20'($urandom);
        endcase
    endfunction

    function automatic t_vertex rand_vertex();
        t_vertex v;
        v.nx = rand_nrm(); v.ny = rand_nrm(); v.nz = rand_nrm();
        v.px = rand_pos(); v.py = rand_pos(); v.pz = rand_pos();
        if ($urandom_range(0, 15) == 0) {v.nx, v.ny, v.nz} = '0;
        return v;
    endfunction

    task automatic random_settings(bit extreme);
        for (int i = 0; i < 3; i++)
            write_reg(t_cfg_idx'(i), extreme ? 60'($urandom_range(0, 1) ? 48'h8000_8000_8000
                : 48'h7fff_7fff_7fff) : 60'({$urandom, $urandom}));
        write_reg(CFG_LIGHT, extreme ? 60'hfffffffffffffff : 60'({$urandom, $urandom}));
        write_reg(CFG_OFFSET, 60'(extreme ? 16'hffff : 16'($urandom)));
        write_reg(CFG_GAIN, 60'(extreme ? 24'hffffff : 24'($urandom)));
        write_reg(CFG_MINCOS, 60'(extreme ? 16'h8000 : 16'($urandom)));
        write_reg(CFG_ENV, 60'($urandom_range(0, 1)));
    endtask

    initial begin
        t_vertex v;
        i_rst_n = 0;
        i_cfg_valid = 0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        m_axis_tready = 0;
        sh_row[0] = 48'd16384;
        sh_row[1] = 48'd1073741824;
        sh_row[2] = 48'd70368744177664;
        sh_light = '0;
        sh_offset = 16'h8000;
        sh_gain = 24'h010000;
        sh_mincos = '0;
        sh_env = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: reset settings, extremes, zero normal and zero light vector
        for (int e = 0; e < 2; e++) begin
            if (e == 1) write_reg(CFG_ENV, 60'd1);
            v = '0; vertex_queue.push_back(v);
            v.nx = 16'h4000; vertex_queue.push_back(v);
            v = '0; v.px = 20'h00100; vertex_queue.push_back(v);
            v = {16'h7fff, 16'h7fff, 16'h7fff, 20'h7ffff, 20'h7ffff, 20'h7ffff};
            vertex_queue.push_back(v);
            v = {16'h8000, 16'h8000, 16'h8000, 20'h80000, 20'h80000, 20'h80000};
            vertex_queue.push_back(v);
            v = {16'h0000, 16'h0000, 16'hc000, 20'h0, 20'h0, 20'h00400};
            vertex_queue.push_back(v);
            v = {16'h0000, 16'h0000, 16'h4000, 20'h0, 20'h0, 20'h00400};
            vertex_queue.push_back(v);
            v = {16'h2d41, 16'h2d41, 16'h0000, 20'h0, 20'h0, 20'h0};
            vertex_queue.push_back(v);
            wait_drained();
        end
        random_settings(1);
        for (int i = 0; i < 6; i++) vertex_queue.push_back(rand_vertex());
        wait_drained();

        // random phases under changing settings
        for (int ph = 0; ph < 10; ph++) begin
            random_settings(ph == 9);
            if ($urandom_range(0, 1)) begin
                write_reg(CFG_ROW0, 60'd16384);
                write_reg(CFG_ROW1, 60'd1073741824);
                write_reg(CFG_ROW2, 60'd70368744177664);
            end
            if (ph == 3) write_reg(CFG_MINCOS, 60'h7fff);
            if (ph == 4) write_reg(CFG_GAIN, 60'h0);
            for (int i = 0; i < N_RANDOM / 10; i++) vertex_queue.push_back(rand_vertex());
            wait_drained();
        end

        if (errors == 0) begin
            $display("point_light_vertex_intensity_top regression: pass");
        end else begin
            $display("point_light_vertex_intensity_top regression: fail");
        end
        $finish;
    end

endmodule
